FILE: hw/rtl/mcpg_pkg.sv
// ----------------------------------------------------------------------------
// mcpg_pkg
// Shared widths and register indexes for the midpoint circle point generator.
// ----------------------------------------------------------------------------
package mcpg_pkg;

    // output coordinate width, two's complement
    localparam int unsigned OUT_W      = 12;
    // decision variable width
    localparam int unsigned DEC_W      = 16;
    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned CENTER_W   = 10;
    localparam int unsigned RADIUS_W   = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;

endpackage

FILE: hw/rtl/mcpg_front.sv
// ----------------------------------------------------------------------------
// mcpg_front
// Accepts restart/advance transactions, keeps the octant offsets and the
// decision variable, and pushes one step command per advance once running.
// ----------------------------------------------------------------------------
module mcpg_front
    import mcpg_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_restart,
    input  logic [RADIUS_W-1:0]      i_radius,
    input  logic                     i_q_ready,
    output logic                     o_q_push,
    output logic [2*COORD_WIDTH:0]   o_q_data
);

    localparam int unsigned CW = COORD_WIDTH;

    logic [CW-1:0]    r_x, n_x;
    logic [CW-1:0]    r_y, n_y;
    logic [DEC_W-1:0] r_dec, n_dec;
    logic             r_running, n_running;

    logic                  accept;
    logic                  arc_done;
    logic                  dec_pos;
    logic [CW-1:0]         y_step;
    logic [CW+RADIUS_W-1:0] rad_wide;
    logic [CW-1:0]         rad_cw;
    logic [CW+DEC_W-1:0]   rad_ext, x_ext, y_ext;
    logic [DEC_W-1:0]      rad16, x16, y16, diff16, dec_inc, dec_init;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;

    // radius limited to the offset width, then widened for the decision
    assign rad_wide = {{CW{1'b0}}, i_radius};
    assign rad_cw   = rad_wide[CW-1:0];
    assign rad_ext  = {{DEC_W{1'b0}}, rad_cw};
    assign rad16    = rad_ext[DEC_W-1:0];
    assign dec_init = 16'd3 - {rad16[DEC_W-2:0], 1'b0};

    // midpoint step
    assign arc_done = (r_y < r_x);
    assign dec_pos  = !r_dec[DEC_W-1] && (r_dec != '0);
    assign y_step   = (dec_pos && (r_y != '0)) ? (r_y - 1'b1) : r_y;
    assign x_ext    = {{DEC_W{1'b0}}, r_x};
    assign y_ext    = {{DEC_W{1'b0}}, y_step};
    assign x16      = x_ext[DEC_W-1:0];
    assign y16      = y_ext[DEC_W-1:0];
    assign diff16   = x16 - y16;
    assign dec_inc  = dec_pos ? ({diff16[DEC_W-3:0], 2'b00} + 16'd10)
                              : ({x16[DEC_W-3:0], 2'b00} + 16'd6);

    // command to the back end: {finished, x, y}
    assign o_q_push = accept && !i_restart && r_running;
    assign o_q_data = {arc_done, r_x, r_y};

    // state update
    always_comb begin
        n_x       = r_x;
        n_y       = r_y;
        n_dec     = r_dec;
        n_running = r_running;
        if (accept) begin
            if (i_restart) begin
                n_x       = '0;
                n_y       = rad_cw;
                n_dec     = dec_init;
                n_running = 1'b1;
            end else if (r_running && !arc_done) begin
                n_x   = r_x + 1'b1;
                n_y   = y_step;
                n_dec = r_dec + dec_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_dec     <= '0;
            r_running <= 1'b0;
        end else begin
            r_x       <= n_x;
            r_y       <= n_y;
            r_dec     <= n_dec;
            r_running <= n_running;
        end
    end

endmodule

FILE: hw/rtl/mcpg_queue.sv
// ----------------------------------------------------------------------------
// mcpg_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mcpg_queue #(
    parameter int unsigned DATA_W = 21
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wptr, n_wptr;
    logic              r_rptr, n_rptr;
    logic [1:0]        r_count, n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    // pointers and fill count
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = ~r_wptr;
        end
        if (i_pop) begin
            n_rptr = ~r_rptr;
        end
        priority if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end else begin
            // push and pop together, or neither: count holds
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("pop from empty queue");

endmodule

FILE: hw/rtl/mcpg_back.sv
// ----------------------------------------------------------------------------
// mcpg_back
// Expands each step command into eight symmetric points, or one finished
// marker, through a registered output stage.
// ----------------------------------------------------------------------------
module mcpg_back
    import mcpg_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  logic [2*COORD_WIDTH:0]  i_q_data,
    output logic                    o_q_pop,
    input  logic [CENTER_W-1:0]     i_center_x,
    input  logic [CENTER_W-1:0]     i_center_y,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_point_x,
    output logic signed [OUT_W-1:0] o_point_y,
    output logic                    o_point_valid,
    output logic                    o_last_of_step,
    output logic                    o_finished
);

    localparam int unsigned CW = COORD_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_bstate;

    t_bstate      r_state, n_state;
    logic [2:0]   r_idx, n_idx;
    logic         r_out_valid, n_out_valid;
    logic [CW-1:0] r_x, n_x;
    logic [CW-1:0] r_y, n_y;
    logic signed [OUT_W-1:0] r_px, n_px;
    logic signed [OUT_W-1:0] r_py, n_py;
    logic         r_pv, n_pv;
    logic         r_last, n_last;
    logic         r_fin, n_fin;

    logic         out_free;
    logic         q_fin;
    logic [CW-1:0] q_x, q_y;
    logic [CW-1:0] src_x, src_y;
    logic [2:0]   src_idx;
    logic [CW+OUT_W-1:0] x_ext, y_ext;
    logic [CW+CENTER_W-1:0] cx_wide, cy_wide;
    logic [CW-1:0] cx_cw, cy_cw;
    logic [CW+OUT_W-1:0] cx_ext, cy_ext;
    logic [OUT_W-1:0] x12, y12, cx12, cy12, a12, b12, px12, py12;

    assign {q_fin, q_x, q_y} = i_q_data;
    assign out_free = !r_out_valid || i_out_ready;

    // center limited to the offset width, everything taken modulo 2^12
    assign cx_wide = {{CW{1'b0}}, i_center_x};
    assign cy_wide = {{CW{1'b0}}, i_center_y};
    assign cx_cw   = cx_wide[CW-1:0];
    assign cy_cw   = cy_wide[CW-1:0];
    assign cx_ext  = {{OUT_W{1'b0}}, cx_cw};
    assign cy_ext  = {{OUT_W{1'b0}}, cy_cw};
    assign cx12    = cx_ext[OUT_W-1:0];
    assign cy12    = cy_ext[OUT_W-1:0];

    // point 0 comes straight from the queue head, the rest from latched offsets
    assign src_x   = (r_state == ST_IDLE) ? q_x : r_x;
    assign src_y   = (r_state == ST_IDLE) ? q_y : r_y;
    assign src_idx = (r_state == ST_IDLE) ? 3'd0 : r_idx;
    assign x_ext   = {{OUT_W{1'b0}}, src_x};
    assign y_ext   = {{OUT_W{1'b0}}, src_y};
    assign x12     = x_ext[OUT_W-1:0];
    assign y12     = y_ext[OUT_W-1:0];

    // index bit 2 swaps the octant, bit 0 negates column, bit 1 negates row
    assign a12  = src_idx[2] ? y12 : x12;
    assign b12  = src_idx[2] ? x12 : y12;
    assign px12 = src_idx[0] ? (cx12 - a12) : (cx12 + a12);
    assign py12 = src_idx[1] ? (cy12 - b12) : (cy12 + b12);

    // sequencer and output stage
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_x         = r_x;
        n_y         = r_y;
        n_px        = r_px;
        n_py        = r_py;
        n_pv        = r_pv;
        n_last      = r_last;
        n_fin       = r_fin;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop     = 1'b1;
                    n_out_valid = 1'b1;
                    n_x         = q_x;
                    n_y         = q_y;
                    if (q_fin) begin
                        n_px   = '0;
                        n_py   = '0;
                        n_pv   = 1'b0;
                        n_last = 1'b1;
                        n_fin  = 1'b1;
                    end else begin
                        n_px    = $signed(px12);
                        n_py    = $signed(py12);
                        n_pv    = 1'b1;
                        n_last  = 1'b0;
                        n_fin   = 1'b0;
                        n_idx   = 3'd1;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_px        = $signed(px12);
                    n_py        = $signed(py12);
                    n_pv        = 1'b1;
                    n_fin       = 1'b0;
                    n_last      = (r_idx == 3'd7);
                    n_idx       = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_px   <= n_px;
        r_py   <= n_py;
        r_pv   <= n_pv;
        r_last <= n_last;
        r_fin  <= n_fin;
    end

    assign o_out_valid    = r_out_valid;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_point_valid  = r_pv;
    assign o_last_of_step = r_last;
    assign o_finished     = r_fin;

    a_fin_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_finished) |-> (o_last_of_step && !o_point_valid))
        else $error("finished marker malformed");

    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx != 3'd0))
        else $error("emit index wrapped while emitting");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && r_idx == 3'd7) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after eighth point");

endmodule

FILE: hw/rtl/midpoint_circle_point_generator_core.sv
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator_core
// Midpoint circle rasterizer: restart/advance transactions in, plotted
// points out, center and radius held in configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   Write center_x, center_y and circle_radius through the cfg port while
//   idle. A transaction with i_restart=1 loads offsets (0, radius) and the
//   decision 3-2r; it produces no result. Each transaction with i_restart=0
//   yields eight points center+-(x,y), center+-(y,x), the eighth marked by
//   o_last_of_step, or, once x has passed y, one finished marker.
//   Advances before the first restart produce nothing.
// Timing:
//   The front end updates offsets in the cycle an item is accepted and
//   queues a step command (two-entry queue). The back end pops it into
//   the output register, which drives o_out_valid and is the limit;
//   results follow at one per cycle while commands are queued and
//   i_out_ready is high. A point-producing step occupies the single-point
//   output channel for its eight points, a finished marker for one.
//   The front accepts while the queue has room, so up to two steps can
//   wait while the receiver stalls; o_in_ready drops when both are full.
// Reset:
//   Synchronous, active low. Clears the config registers, offsets, decision
//   and the running flag; the queue and output stage come up empty.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator_core
    import mcpg_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_restart,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [OUT_W-1:0] o_point_x,
    output logic signed [OUT_W-1:0] o_point_y,
    output logic                    o_point_valid,
    output logic                    o_last_of_step,
    output logic                    o_finished
);

    localparam int unsigned QW = 2 * COORD_WIDTH + 1;

    logic [CENTER_W-1:0] r_center_x;
    logic [CENTER_W-1:0] r_center_y;
    logic [RADIUS_W-1:0] r_radius;

    logic          q_push, q_ready, q_pop, q_valid;
    logic [QW-1:0] q_wdata, q_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_radius   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X: r_center_x <= i_cfg_wdata;
                REG_CENTER_Y: r_center_y <= i_cfg_wdata;
                REG_RADIUS:   r_radius   <= i_cfg_wdata[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mcpg_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_restart  (i_restart),
        .i_radius   (r_radius),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata)
    );

    mcpg_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    mcpg_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_rdata),
        .o_q_pop        (q_pop),
        .i_center_x     (r_center_x),
        .i_center_y     (r_center_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_valid  (o_point_valid),
        .o_last_of_step (o_last_of_step),
        .o_finished     (o_finished)
    );

endmodule
